FILE: hw/rtl/mlpb_pkg.sv
// Shared types and constants of the multi-LED pulse blinker.
`timescale 1ns / 1ps
`default_nettype none

package mlpb_pkg;

    localparam int MODE_W   = 3;
    localparam int IDX_W    = 3;
    localparam int PERIOD_W = 32;
    localparam int COUNT_W  = 16;
    localparam int HALF_W   = 31;
    localparam int HALVES_W = 17;
    localparam int MASK_W   = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ON     = 3'd0,
        MODE_OFF    = 3'd1,
        MODE_TOGGLE = 3'd2,
        MODE_START  = 3'd3,
        MODE_STOP   = 3'd4,
        MODE_TICK   = 3'd5
    } t_mode;

    typedef struct packed {
        logic                en;
        logic                tick;
        logic                hit;
        t_mode               mode;
        logic [HALF_W-1:0]   half;
        logic                endless;
        logic [HALVES_W-1:0] halves;
    } t_lane_cmd;

endpackage

`default_nettype wire

FILE: hw/rtl/mlpb_lane.sv
// Per-LED level, pulse timer and half-period counter.
`timescale 1ns / 1ps
`default_nettype none

module mlpb_lane
    import mlpb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_lane_cmd i_cmd,
    output logic           o_level,
    output logic           o_running,
    output logic           o_n_level,
    output logic           o_n_running
);

    logic                r_level;
    logic                r_running;
    logic                r_forever;
    logic [HALVES_W-1:0] r_halves;
    logic [HALF_W-1:0]   r_reload;
    logic [HALF_W-1:0]   r_countdown;

    logic                n_level;
    logic                n_running;
    logic                n_forever;
    logic [HALVES_W-1:0] n_halves;
    logic [HALF_W-1:0]   n_reload;
    logic [HALF_W-1:0]   n_countdown;
    logic [HALVES_W-1:0] w_halves_dec;

    always_comb begin
        n_level      = r_level;
        n_running    = r_running;
        n_forever    = r_forever;
        n_halves     = r_halves;
        n_reload     = r_reload;
        n_countdown  = r_countdown;
        w_halves_dec = r_halves;
        if (i_cmd.en && i_cmd.tick && r_running) begin
            if (r_countdown > HALF_W'(1)) begin
                n_countdown = r_countdown - HALF_W'(1);
            end else begin
                n_countdown = r_reload;
                if (!r_forever && (r_halves != '0)) begin
                    w_halves_dec = r_halves - HALVES_W'(1);
                end
                n_halves = w_halves_dec;
                if (!r_forever && (w_halves_dec == '0)) begin
                    n_level   = 1'b0;
                    n_running = 1'b0;
                end else begin
                    n_level = !r_level;
                end
            end
        end else if (i_cmd.en && i_cmd.hit) begin
            unique case (i_cmd.mode)
                MODE_ON: begin
                    n_running = 1'b0;
                    n_forever = 1'b0;
                    n_halves  = '0;
                    n_level   = 1'b1;
                end
                MODE_OFF: begin
                    n_running = 1'b0;
                    n_forever = 1'b0;
                    n_halves  = '0;
                    n_level   = 1'b0;
                end
                MODE_TOGGLE: begin
                    n_running = 1'b0;
                    n_forever = 1'b0;
                    n_halves  = '0;
                    n_level   = !r_level;
                end
                MODE_START: begin
                    n_reload    = i_cmd.half;
                    n_countdown = i_cmd.half;
                    n_forever   = i_cmd.endless;
                    n_halves    = i_cmd.halves;
                    n_running   = 1'b1;
                    n_level     = 1'b1;
                end
                MODE_STOP: begin
                    n_running = 1'b0;
                    n_level   = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= 1'b0;
            r_running <= 1'b0;
            r_forever <= 1'b0;
            r_halves  <= '0;
        end else begin
            r_level   <= n_level;
            r_running <= n_running;
            r_forever <= n_forever;
            r_halves  <= n_halves;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reload    <= n_reload;
        r_countdown <= n_countdown;
    end

    assign o_level     = r_level;
    assign o_running   = r_running;
    assign o_n_level   = n_level;
    assign o_n_running = n_running;

endmodule

`default_nettype wire

FILE: hw/rtl/multi_led_pulse_blinker.sv
// Top level of the multi-LED pulse blinker: input register, LED lanes, result register.
`timescale 1ns / 1ps
`default_nettype none

// Each beat is one command for one LED (on, off, toggle, start pulsing, stop) or a
// time tick that advances every running LED timer at once. A beat is captured in an
// input register and applied to all lanes once the result register is free; that
// register then takes the LED levels and pulsing mask as they stand after the beat.
// One beat per clock is sustained while the result is not stalled, and a stalled
// result holds the input register. Commands to an LED whose enable bit is clear,
// or beyond NUM_LEDS, change nothing but still yield a result. Write the enable mask
// only while no beat is in flight.
module multi_led_pulse_blinker
    import mlpb_pkg::*;
#(
    parameter int NUM_LEDS = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [MODE_W-1:0]   i_mode,
    input  wire logic [IDX_W-1:0]    i_led_index,
    input  wire logic [PERIOD_W-1:0] i_pulse_period,
    input  wire logic [COUNT_W-1:0]  i_pulse_count,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [MASK_W-1:0]        o_led_levels,
    output logic [MASK_W-1:0]        o_pulsing_mask,
    input  wire logic                i_cfg_we,
    input  wire logic [MASK_W-1:0]   i_cfg_wdata
);

    logic                r_in_valid;
    logic [MODE_W-1:0]   r_mode;
    logic [IDX_W-1:0]    r_led_index;
    logic [PERIOD_W-1:0] r_period;
    logic [COUNT_W-1:0]  r_count;
    logic [MASK_W-1:0]   r_mask;
    logic                r_out_valid;
    logic [MASK_W-1:0]   r_led_levels;
    logic [MASK_W-1:0]   r_pulsing_mask;

    logic                w_fire;
    logic                w_in_range;
    logic                w_hit;
    logic [HALF_W-1:0]   w_half;
    logic [NUM_LEDS-1:0] w_level;
    logic [NUM_LEDS-1:0] w_running;
    logic [NUM_LEDS-1:0] w_n_level;
    logic [NUM_LEDS-1:0] w_n_running;
    t_lane_cmd           w_cmd_base;

    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_mode      <= i_mode;
            r_led_index <= i_led_index;
            r_period    <= i_pulse_period;
            r_count     <= i_pulse_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_W'(1);
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    assign w_in_range = ({1'b0, r_led_index} < (IDX_W + 1)'(NUM_LEDS));
    assign w_hit      = (r_mode <= MODE_STOP) && w_in_range && r_mask[r_led_index];
    assign w_half     = (r_period[PERIOD_W-1:1] == '0) ? HALF_W'(1) : r_period[PERIOD_W-1:1];

    always_comb begin
        w_cmd_base         = '0;
        w_cmd_base.en      = w_fire;
        w_cmd_base.tick    = (r_mode == MODE_TICK);
        w_cmd_base.mode    = t_mode'(r_mode);
        w_cmd_base.half    = w_half;
        w_cmd_base.endless = (r_count == '0);
        w_cmd_base.halves  = {r_count, 1'b0};
    end

    for (genvar g = 0; g < NUM_LEDS; g++) begin : g_lane
        t_lane_cmd w_cmd;

        always_comb begin
            w_cmd     = w_cmd_base;
            w_cmd.hit = w_hit && (r_led_index == IDX_W'(g));
        end

        mlpb_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .o_level     (w_level[g]),
            .o_running   (w_running[g]),
            .o_n_level   (w_n_level[g]),
            .o_n_running (w_n_running[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_led_levels   <= MASK_W'(w_n_level);
            r_pulsing_mask <= MASK_W'(w_n_running);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_led_levels   = r_led_levels;
    assign o_pulsing_mask = r_pulsing_mask;

`ifndef SYNTHESIS
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed beat did not produce a result");

    a_pulse_only_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_mode != MODE_START)) |-> ((w_n_running & ~w_running) == '0))
        else $error("pulse timer started by a beat other than start");

    a_ignored_cmd_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_mode != MODE_TICK) && !w_hit) |->
        ((w_n_level == w_level) && (w_n_running == w_running)))
        else $error("ignored command changed LED state");

    a_idle_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |-> ((w_n_level == w_level) && (w_n_running == w_running)))
        else $error("LED state changed without a beat");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the multi-LED pulse blinker: LED state scoreboard and drivers.
`timescale 1ns / 1ps

module tb;
    import mlpb_pkg::*;

    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;
    localparam int NUM_LEDS      = 8;
    localparam int BEATS_PER_SET = 190;
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 6;

    typedef struct packed {
        logic [MASK_W-1:0] levels;
        logic [MASK_W-1:0] pulsing;
    } led_snapshot_t;

    class blink_scoreboard;
        logic [MASK_W-1:0]   led_mask = 8'h01;
        logic [NUM_LEDS-1:0] lit = '0;
        logic [NUM_LEDS-1:0] armed = '0;
        logic [NUM_LEDS-1:0] endless = '0;
        logic [HALVES_W-1:0] halves_left [NUM_LEDS];
        logic [HALF_W-1:0]   half_reload [NUM_LEDS];
        logic [HALF_W-1:0]   countdown [NUM_LEDS];
        led_snapshot_t       pending_levels [$];
        int                  errors = 0;

        function int pending();
            return pending_levels.size();
        endfunction

        function void advance_timers();
            for (int i = 0; i < NUM_LEDS; i++) begin
                if (armed[i]) begin
                    if (countdown[i] > 1) begin
                        countdown[i] = countdown[i] - 1'b1;
                    end else begin
                        countdown[i] = half_reload[i];
                        if (!endless[i] && halves_left[i] != 0)
                            halves_left[i] = halves_left[i] - 1'b1;
                        if (!endless[i] && halves_left[i] == 0) begin
                            lit[i]   = 1'b0;
                            armed[i] = 1'b0;
                        end else begin
                            lit[i] = ~lit[i];
                        end
                    end
                end
            end
        endfunction

        function void note_beat(logic [MODE_W-1:0] md, logic [IDX_W-1:0] ix,
                                logic [PERIOD_W-1:0] per, logic [COUNT_W-1:0] cnt);
            logic [HALF_W-1:0] half;
            half = per[PERIOD_W-1:1];
            if (half == 0)
                half = HALF_W'(1);
            if (md == MODE_TICK) begin
                advance_timers();
            end else if (md <= MODE_STOP && ix < NUM_LEDS && led_mask[ix]) begin
                case (md)
                    MODE_ON, MODE_OFF, MODE_TOGGLE: begin
                        armed[ix]       = 1'b0;
                        endless[ix]     = 1'b0;
                        halves_left[ix] = '0;
                        if (md == MODE_ON)
                            lit[ix] = 1'b1;
                        else if (md == MODE_OFF)
                            lit[ix] = 1'b0;
                        else
                            lit[ix] = ~lit[ix];
                    end
                    MODE_START: begin
                        half_reload[ix] = half;
                        countdown[ix]   = half;
                        endless[ix]     = (cnt == 0);
                        halves_left[ix] = {cnt, 1'b0};
                        armed[ix]       = 1'b1;
                        lit[ix]         = 1'b1;
                    end
                    default: begin
                        armed[ix] = 1'b0;
                        lit[ix]   = 1'b0;
                    end
                endcase
            end
            pending_levels.push_back({lit, armed});
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 10)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        function void check_result(logic [MASK_W-1:0] levels, logic [MASK_W-1:0] pulsing);
            led_snapshot_t want;
            if (pending_levels.size() == 0) begin
                report($sformatf("unexpected beat levels=%h pulsing=%h", levels, pulsing));
            end else begin
                want = pending_levels.pop_front();
                if (levels !== want.levels)
                    report($sformatf("led_levels exp=%h got=%h", want.levels, levels));
                if (pulsing !== want.pulsing)
                    report($sformatf("pulsing_mask exp=%h got=%h", want.pulsing, pulsing));
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [MODE_W-1:0]   in_mode = '0;
    logic [IDX_W-1:0]    in_led_index = '0;
    logic [PERIOD_W-1:0] in_pulse_period = '0;
    logic [COUNT_W-1:0]  in_pulse_count = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [MASK_W-1:0]   out_led_levels;
    logic [MASK_W-1:0]   out_pulsing_mask;
    logic                cfg_we = 1'b0;
    logic [MASK_W-1:0]   cfg_wdata = '0;

    blink_scoreboard sb;
    int              burst_left = 0;
    bit              gaps_on = 1'b1;
    int              idle_cycles = 0;
    logic [15:0]     stall_pattern = 16'hFFFF;
    logic [5:0]      rx_phase = '0;

    multi_led_pulse_blinker #(
        .NUM_LEDS(NUM_LEDS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_mode         (in_mode),
        .i_led_index    (in_led_index),
        .i_pulse_period (in_pulse_period),
        .i_pulse_count  (in_pulse_count),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_led_levels   (out_led_levels),
        .o_pulsing_mask (out_pulsing_mask),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && in_ready)
                sb.note_beat(in_mode, in_led_index, in_pulse_period, in_pulse_count);
            if (out_valid && out_ready)
                sb.check_result(out_led_levels, out_pulsing_mask);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("multi_led_pulse_blinker verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        rx_phase <= rx_phase + 1'b1;
        if (rx_phase == 0)
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                          : (16'($urandom) | 16'h0101);
        out_ready <= stall_pattern[rx_phase[3:0]];
    end

    task automatic send_beat(input logic [MODE_W-1:0] md, input logic [IDX_W-1:0] ix,
                             input logic [PERIOD_W-1:0] per, input logic [COUNT_W-1:0] cnt);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                @(negedge i_clk);
                in_valid = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_valid        = 1'b1;
        in_mode         = md;
        in_led_index    = ix;
        in_pulse_period = per;
        in_pulse_count  = cnt;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (HOLD_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] value);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(posedge i_clk);
        sb.led_mask = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_random_set(input int beats);
        logic [MODE_W-1:0]   md;
        logic [IDX_W-1:0]    ix;
        logic [PERIOD_W-1:0] per;
        logic [COUNT_W-1:0]  cnt;
        int                  r;
        int                  sel;
        int                  counted;
        counted = 0;
        while (counted < beats) begin
            r   = $urandom_range(0, 99);
            ix  = IDX_W'($urandom_range(0, NUM_LEDS - 1));
            per = $urandom;
            cnt = COUNT_W'($urandom);
            if (r < 45) begin
                md = MODE_TICK;
            end else if (r < 62) begin
                md  = MODE_START;
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    per = $urandom_range(0, 12);
                else if (sel < 9)
                    per = $urandom_range(13, 100);
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    cnt = COUNT_W'($urandom_range(0, 4));
                else if (sel < 9)
                    cnt = COUNT_W'($urandom_range(5, 40));
            end else if (r < 68) begin
                md = MODE_ON;
            end else if (r < 74) begin
                md = MODE_OFF;
            end else if (r < 80) begin
                md = MODE_TOGGLE;
            end else if (r < 88) begin
                md = MODE_STOP;
            end else if (r < 93) begin
                md = r[0] ? MODE_RSVD7 : MODE_RSVD6;
            end else begin
                md = MODE_W'($urandom_range(0, 7));
            end
            counted++;
            send_beat(md, ix, per, cnt);
        end
    endtask

    initial begin
        logic [MASK_W-1:0] set_masks [7];
        sb = new;
        set_masks[0] = 8'h01;
        set_masks[1] = 8'hFF;
        set_masks[2] = 8'h00;
        set_masks[3] = 8'h5A;
        set_masks[4] = MASK_W'($urandom_range(0, 255));
        set_masks[5] = 8'h80;
        set_masks[6] = 8'hFF;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_beat(MODE_ON, 3'd0, '0, '0);
        send_beat(MODE_TOGGLE, 3'd0, '0, '0);
        send_beat(MODE_TOGGLE, 3'd0, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(MODE_OFF, 3'd0, '0, '0);
        send_beat(MODE_STOP, 3'd0, '0, '0);
        send_beat(MODE_ON, 3'd1, '0, '0);
        send_beat(MODE_RSVD6, 3'd0, '0, '0);
        send_beat(MODE_RSVD7, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(MODE_START, 3'd0, 32'd0, 16'd1);
        send_beat(MODE_TICK, 3'd0, '0, '0);
        send_beat(MODE_TICK, 3'd0, '0, '0);
        send_beat(MODE_START, 3'd0, 32'd1, 16'd0);
        send_beat(MODE_TICK, 3'd0, '0, '0);
        send_beat(MODE_TICK, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(MODE_TOGGLE, 3'd0, '0, '0);
        send_beat(MODE_TICK, 3'd0, '0, '0);
        send_beat(MODE_START, 3'd0, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(MODE_TICK, 3'd0, '0, '0);
        send_beat(MODE_STOP, 3'd0, '0, '0);
        send_beat(MODE_START, 3'd0, 32'd6, 16'd2);
        send_beat(MODE_START, 3'd2, 32'd4, 16'd1);
        repeat (3) send_beat(MODE_TICK, 3'd0, '0, '0);

        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                drain();
                write_mask(set_masks[p]);
            end
            gaps_on = (p % 3 != 1);
            send_random_set(BEATS_PER_SET);
        end

        drain();
        if (sb.pending() != 0)
            sb.report("expected beats left over");
        if (sb.errors == 0) begin
            $display("multi_led_pulse_blinker verification clean");
        end else begin
            $display("multi_led_pulse_blinker verification failed");
        end
        $finish;
    end

endmodule
